### hdl/char_lcd_controller_defines.svh
// assertion macros for the character lcd controller checker
// needs clk and rst_n in the scope where the macros are used
`ifndef CHAR_LCD_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_CONTROLLER_DEFINES_SVH

// condition and consequence in the same cycle
`define CLCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/clcd_pkg.sv
// shared constants, command decode and pointer arithmetic for the
// character lcd controller; no dependencies
`default_nettype none
package clcd_pkg;

  localparam int DDRAM_SIZE = 80;
  localparam int CGRAM_SIZE = 64;
  localparam int DD_AW      = $clog2(DDRAM_SIZE);
  localparam int CG_AW      = $clog2(CGRAM_SIZE);

  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [DD_AW-1:0] DD_LAST    = DD_AW'(DDRAM_SIZE - 1);
  localparam logic [DD_AW-1:0] SHORT_LAST = DD_AW'(39);
  localparam logic [DD_AW-1:0] SHORT_LEN  = DD_AW'(40);

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_HOME,
    CMD_ENTRY,
    CMD_DISPLAY,
    CMD_SHIFT,
    CMD_FUNCTION,
    CMD_SET_CGRAM,
    CMD_SET_DDRAM
  } cmd_t;

  // highest set bit picks the command
  function automatic cmd_t cmd_decode(input logic [7:0] c);
    cmd_t k;
    if (c[7])      k = CMD_SET_DDRAM;
    else if (c[6]) k = CMD_SET_CGRAM;
    else if (c[5]) k = CMD_FUNCTION;
    else if (c[4]) k = CMD_SHIFT;
    else if (c[3]) k = CMD_DISPLAY;
    else if (c[2]) k = CMD_ENTRY;
    else if (c[1]) k = CMD_HOME;
    else           k = CMD_CLEAR;
    return k;
  endfunction

  // shift offset wraps within one line
  function automatic logic [DD_AW-1:0] next_shift(input logic [DD_AW-1:0] s,
                                                  input logic up,
                                                  input logic short_lines);
    logic [DD_AW-1:0] last;
    logic [DD_AW-1:0] r;
    last = short_lines ? SHORT_LAST : DD_LAST;
    if (up) r = (s >= last) ? '0 : s + 1'b1;
    else    r = (s == '0) ? last : s - 1'b1;
    return r;
  endfunction

  // address counter wraps over the whole display ram
  function automatic logic [DD_AW-1:0] next_addr(input logic [DD_AW-1:0] a,
                                                 input logic up);
    logic [DD_AW-1:0] r;
    if (up) r = (a >= DD_LAST) ? '0 : a + 1'b1;
    else    r = (a == '0) ? DD_LAST : a - 1'b1;
    return r;
  endfunction

  // set ddram address: fold the second line of 40-char mode, then wrap
  function automatic logic [DD_AW-1:0] ddram_addr(input logic [DD_AW-1:0] a,
                                                  input logic short_lines);
    logic [DD_AW-1:0] t;
    t = a;
    if (short_lines && (a > DD_AW'(63))) t = a - DD_AW'(24);
    if (t > DD_LAST) t = t - DD_AW'(DDRAM_SIZE);
    return t;
  endfunction

endpackage
`default_nettype wire

### hdl/char_lcd_controller.sv
// character lcd controller top level: bus strobe decode, command execution,
// display and glyph rams; depends on clcd_pkg, clcd_ram, clcd_cell_map
//
// usage:
//   an item is taken when start is high and busy is low. in_req_type 0 is a
//   bus strobe (in_rs, in_bus_data), 1 is a screen cell fetch (in_row,
//   in_col, in_glyph_line). every item gives one result, shown for one cycle
//   with out_valid high; the receiver cannot stall, so results are never held.
//   status outputs always show the live controller state.
//   results and throughput:
//     strobe other than clear: result in the cycle after the item, busy stays
//       low, so one strobe per cycle
//     cell fetch: result after the display ram read followed by the
//       dependent glyph ram read
//     clear: result at the end of the sweep, one display ram entry written
//       per cycle by the sweep
//   reset: rst_n low clears all control state; after release an init
//   pass fills the display ram with spaces and the glyph ram with zero,
//   with busy high and no result.
`default_nettype none
module char_lcd_controller (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_req_type,
  input  wire logic       in_rs,
  input  wire logic [7:0] in_bus_data,
  input  wire logic [1:0] in_row,
  input  wire logic [4:0] in_col,
  input  wire logic [2:0] in_glyph_line,
  output logic            out_valid,
  output logic [7:0]      out_char_code,
  output logic [7:0]      out_pattern_row,
  output logic            out_cursor_here,
  output logic            out_display_on,
  output logic            out_cursor_blink,
  output logic [clcd_pkg::DD_AW-1:0] out_address_counter,
  output logic [clcd_pkg::CG_AW-1:0] out_cgram_address,
  output logic [clcd_pkg::DD_AW-1:0] out_shift_position,
  output logic            out_four_bit_mode,
  output logic            out_forty_char_lines,
  output logic            out_awaiting_low_nibble,
  output logic            out_selects_cgram
);
  import clcd_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_GLYPH,
    S_PAT
  } state_t;

  state_t           state_r, state_nxt;
  logic [DD_AW-1:0] cnt_r, cnt_nxt;
  logic [DD_AW-1:0] ddram_ptr_r, ddram_ptr_nxt;
  logic [CG_AW-1:0] cgram_ptr_r, cgram_ptr_nxt;
  logic [DD_AW-1:0] shift_r, shift_nxt;
  logic             dec_r, dec_nxt;
  logic             ashift_r, ashift_nxt;
  logic             disp_r, disp_nxt;
  logic             cur_en_r, cur_en_nxt;
  logic             blink_r, blink_nxt;
  logic             narrow_r, narrow_nxt;
  logic             short_r, short_nxt;
  logic             phase_r, phase_nxt;
  logic [3:0]       held_r, held_nxt;
  logic             wtg_r, wtg_nxt;
  logic [2:0]       line_r, line_nxt;
  logic             cur_hit_r, cur_hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       pat_r, pat_nxt;
  logic             cur_out_r, cur_out_nxt;

  logic             accept;
  logic [7:0]       byte_val;
  logic [DD_AW-1:0] cell_pos;

  logic             dd_we;
  logic [DD_AW-1:0] dd_waddr;
  logic [7:0]       dd_wdata;
  logic [7:0]       dd_rdata;
  logic             cg_we;
  logic [CG_AW-1:0] cg_waddr;
  logic [7:0]       cg_wdata;
  logic [CG_AW-1:0] cg_raddr;
  logic [7:0]       cg_rdata;

  clcd_cell_map u_map (
    .row         (in_row),
    .col         (in_col),
    .shift       (shift_r),
    .short_lines (short_r),
    .pos         (cell_pos)
  );

  clcd_ram #(.WIDTH(8), .DEPTH(DDRAM_SIZE)) u_ddram (
    .clk   (clk),
    .we    (dd_we),
    .waddr (dd_waddr),
    .wdata (dd_wdata),
    .raddr (cell_pos),
    .rdata (dd_rdata)
  );

  clcd_ram #(.WIDTH(8), .DEPTH(CGRAM_SIZE)) u_cgram (
    .clk   (clk),
    .we    (cg_we),
    .waddr (cg_waddr),
    .wdata (cg_wdata),
    .raddr (cg_raddr),
    .rdata (cg_rdata)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign byte_val = narrow_r ? {held_r, in_bus_data[7:4]} : in_bus_data;
  // glyph row of a user character: code low bits and line
  assign cg_raddr = {dd_rdata[2:0], line_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ddram_ptr_nxt = ddram_ptr_r;
    cgram_ptr_nxt = cgram_ptr_r;
    shift_nxt     = shift_r;
    dec_nxt       = dec_r;
    ashift_nxt    = ashift_r;
    disp_nxt      = disp_r;
    cur_en_nxt    = cur_en_r;
    blink_nxt     = blink_r;
    narrow_nxt    = narrow_r;
    short_nxt     = short_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    wtg_nxt       = wtg_r;
    line_nxt      = line_r;
    cur_hit_nxt   = cur_hit_r;
    out_valid_nxt = 1'b0;
    code_nxt      = code_r;
    pat_nxt       = pat_r;
    cur_out_nxt   = cur_out_r;
    dd_we         = 1'b0;
    dd_waddr      = ddram_ptr_r;
    dd_wdata      = byte_val;
    cg_we         = 1'b0;
    cg_waddr      = cgram_ptr_r;
    cg_wdata      = byte_val;

    unique case (state_r)
      S_INIT: begin
        dd_we    = 1'b1;
        dd_waddr = cnt_r;
        dd_wdata = SPACE_CHAR;
        cg_we    = (cnt_r < DD_AW'(CGRAM_SIZE));
        cg_waddr = cnt_r[CG_AW-1:0];
        cg_wdata = 8'd0;
        if (cnt_r == DD_LAST) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_req_type) begin
            line_nxt    = in_glyph_line;
            cur_hit_nxt = (cell_pos == ddram_ptr_r) && cur_en_r;
            state_nxt   = S_GLYPH;
          end else begin
            code_nxt      = 8'd0;
            pat_nxt       = 8'd0;
            cur_out_nxt   = 1'b0;
            out_valid_nxt = 1'b1;
            if (narrow_r && !phase_r) begin
              held_nxt  = in_bus_data[7:4];
              phase_nxt = 1'b1;
            end else begin
              phase_nxt = 1'b0;
              if (in_rs) begin
                if (wtg_r) begin
                  cg_we         = 1'b1;
                  cgram_ptr_nxt = cgram_ptr_r + 1'b1;
                end else begin
                  dd_we         = 1'b1;
                  ddram_ptr_nxt = next_addr(ddram_ptr_r, !dec_r);
                  if (ashift_r) shift_nxt = next_shift(shift_r, !dec_r, short_r);
                end
              end else begin
                unique case (cmd_decode(byte_val))
                  CMD_CLEAR: begin
                    ddram_ptr_nxt = '0;
                    shift_nxt     = '0;
                    cnt_nxt       = '0;
                    out_valid_nxt = 1'b0;
                    state_nxt     = S_CLEAR;
                  end
                  CMD_HOME: begin
                    ddram_ptr_nxt = '0;
                    shift_nxt     = '0;
                  end
                  CMD_ENTRY: begin
                    dec_nxt    = !byte_val[1];
                    ashift_nxt = byte_val[0];
                  end
                  CMD_DISPLAY: begin
                    disp_nxt   = byte_val[2];
                    cur_en_nxt = byte_val[1];
                    blink_nxt  = byte_val[0];
                  end
                  CMD_SHIFT: begin
                    if (byte_val[3]) shift_nxt = next_shift(shift_r, byte_val[2], short_r);
                    else             ddram_ptr_nxt = next_addr(ddram_ptr_r, byte_val[2]);
                  end
                  CMD_FUNCTION: begin
                    narrow_nxt = !byte_val[4];
                    short_nxt  = byte_val[3];
                    if (byte_val[3] && (shift_r > SHORT_LAST)) shift_nxt = shift_r - SHORT_LEN;
                  end
                  CMD_SET_CGRAM: begin
                    cgram_ptr_nxt = byte_val[CG_AW-1:0];
                    wtg_nxt       = 1'b1;
                  end
                  CMD_SET_DDRAM: begin
                    ddram_ptr_nxt = ddram_addr(byte_val[DD_AW-1:0], short_r);
                    wtg_nxt       = 1'b0;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
      end

      S_CLEAR: begin
        dd_we    = 1'b1;
        dd_waddr = cnt_r;
        dd_wdata = SPACE_CHAR;
        if (cnt_r == DD_LAST) begin
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_GLYPH: begin
        // display ram data arrives now, glyph read goes out
        code_nxt  = dd_rdata;
        state_nxt = S_PAT;
      end

      S_PAT: begin
        pat_nxt       = (code_r < 8'd8) ? cg_rdata : 8'd0;
        cur_out_nxt   = cur_hit_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      ddram_ptr_r <= '0;
      cgram_ptr_r <= '0;
      shift_r     <= '0;
      dec_r       <= 1'b0;
      ashift_r    <= 1'b0;
      disp_r      <= 1'b0;
      cur_en_r    <= 1'b0;
      blink_r     <= 1'b0;
      narrow_r    <= 1'b0;
      short_r     <= 1'b0;
      phase_r     <= 1'b0;
      held_r      <= '0;
      wtg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ddram_ptr_r <= ddram_ptr_nxt;
      cgram_ptr_r <= cgram_ptr_nxt;
      shift_r     <= shift_nxt;
      dec_r       <= dec_nxt;
      ashift_r    <= ashift_nxt;
      disp_r      <= disp_nxt;
      cur_en_r    <= cur_en_nxt;
      blink_r     <= blink_nxt;
      narrow_r    <= narrow_nxt;
      short_r     <= short_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      wtg_r       <= wtg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    line_r    <= line_nxt;
    cur_hit_r <= cur_hit_nxt;
    code_r    <= code_nxt;
    pat_r     <= pat_nxt;
    cur_out_r <= cur_out_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_char_code           = code_r;
  assign out_pattern_row         = pat_r;
  assign out_cursor_here         = cur_out_r;
  assign out_display_on          = disp_r;
  assign out_cursor_blink        = blink_r;
  assign out_address_counter     = ddram_ptr_r;
  assign out_cgram_address       = cgram_ptr_r;
  assign out_shift_position      = shift_r;
  assign out_four_bit_mode       = narrow_r;
  assign out_forty_char_lines    = short_r;
  assign out_awaiting_low_nibble = phase_r;
  assign out_selects_cgram       = wtg_r;

endmodule
`default_nettype wire

### hdl/clcd_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none
module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/clcd_cell_map.sv
// maps a screen row and column through the display shift to a ddram address
// depends on clcd_pkg
`default_nettype none
module clcd_cell_map (
  input  wire logic [1:0]                row,
  input  wire logic [4:0]                col,
  input  wire logic [clcd_pkg::DD_AW-1:0] shift,
  input  wire logic                      short_lines,
  output logic      [clcd_pkg::DD_AW-1:0] pos
);
  import clcd_pkg::*;

  logic [4:0]       col_c;
  logic [DD_AW-1:0] row_base;
  logic [DD_AW-1:0] base;
  logic [DD_AW:0]   sum;
  logic [DD_AW:0]   adj;
  logic             over;

  always_comb begin
    col_c = (col > 5'd19) ? 5'd19 : col;
    unique case (row)
      2'd0:    row_base = DD_AW'(0);
      2'd1:    row_base = DD_AW'(40);
      2'd2:    row_base = DD_AW'(20);
      default: row_base = DD_AW'(60);
    endcase
    base = row_base + DD_AW'(col_c);
    sum  = {1'b0, base} + {1'b0, shift};
    // first line of a 40-char display wraps at 39, everything else at 79
    if (short_lines && (base < SHORT_LEN)) over = sum > (DD_AW+1)'(SHORT_LAST);
    else                                   over = sum > (DD_AW+1)'(DD_LAST);
    if (over) adj = sum - (short_lines ? (DD_AW+1)'(40) : (DD_AW+1)'(DDRAM_SIZE));
    else      adj = sum;
    pos = (adj > (DD_AW+1)'(DD_LAST)) ? DD_LAST : adj[DD_AW-1:0];
  end

endmodule
`default_nettype wire

### hdl/clcd_checker.sv
// port-level checks for the character lcd controller, bound to the top level
// depends on clcd_pkg and char_lcd_controller_defines.svh
`default_nettype none
`include "char_lcd_controller_defines.svh"
module clcd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_req_type,
  input wire logic       in_rs,
  input wire logic       out_valid,
  input wire logic [7:0] out_char_code,
  input wire logic [7:0] out_pattern_row,
  input wire logic [clcd_pkg::DD_AW-1:0] out_shift_position,
  input wire logic       out_forty_char_lines
);
  import clcd_pkg::*;

  logic data_acc;
  logic fetch_acc;
  logic builtin_code;
  logic pat_zero;
  logic shift_in_line;

  assign data_acc      = start && !busy && !in_req_type && in_rs;
  assign fetch_acc     = start && !busy && in_req_type;
  assign builtin_code  = out_valid && (out_char_code > 8'd7);
  assign pat_zero      = (out_pattern_row == 8'd0);
  assign shift_in_line = (out_shift_position < SHORT_LEN);

  // results only come out while the controller is free again
  `CLCD_ASSERT_SAME(a_valid_not_busy, out_valid, !busy, "result strobe while busy")

  // a data strobe never starts a sweep, so its result follows at once
  `CLCD_ASSERT_NEXT(a_data_one_cycle, data_acc, out_valid && !busy, "data strobe result missing")

  // a cell fetch waits on two ram reads
  `CLCD_ASSERT_NEXT(a_fetch_holds_busy, fetch_acc, busy && !out_valid, "fetch result early")

  // only user characters carry a pattern row
  `CLCD_ASSERT_SAME(a_pattern_user, builtin_code, pat_zero, "pattern on built-in code")

  // with 40-char lines the shift stays within one line
  `CLCD_ASSERT_SAME(a_short_shift, out_forty_char_lines, shift_in_line, "shift past line end")

endmodule

bind char_lcd_controller clcd_checker u_clcd_checker (.*);
`default_nettype wire
